// ----- design/fed_fragment_sequencer_defines.svh -----
// ----------------------------------------------------------------------------
// fed_fragment_sequencer_defines.svh
// Assertion macros used by the sequencer's checker file.
// ----------------------------------------------------------------------------
`ifndef FED_FRAGMENT_SEQUENCER_DEFINES_SVH
`define FED_FRAGMENT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on aclk and off while in reset.
`define FFS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fed_fragment_sequencer check failed");

// Next-cycle implication, sampled on aclk and off while in reset.
`define FFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fed_fragment_sequencer check failed");

`endif

// ----- design/ffs_pkg.sv -----
// ----------------------------------------------------------------------------
// ffs_pkg
// Widths, codes and beat layouts of the fragment sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffs_pkg;

    localparam int MAX_SOURCES   = 32;
    localparam int HEADER_BYTES  = 8;
    localparam int TRAILER_BYTES = 8;
    localparam int CHUNK_UNIT    = 8;

    localparam int BYTES_W = 24;
    localparam int SRC_W   = 12;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = $clog2(MAX_SOURCES + 1);
    localparam int SLOT_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [BYTES_W-1:0] PAYLOAD_RESET = BYTES_W'(1024);

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_START   = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_CONSUME = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRAILER = 2'd2
    } kind_t;

    // Register word index, taken from paddr[2].
    localparam logic REG_PAYLOAD_BYTES = 1'b0;

endpackage

// ----- design/fed_fragment_sequencer.sv -----
// ----------------------------------------------------------------------------
// fed_fragment_sequencer
// Steps through a super-fragment of header, payload chunks and trailer per
// source, advancing one component per consume beat.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_*       in   tuser: action; tdata: source_id, source_count, bytes_available
//  m_*       out  tuser: comp_kind; tdata: comp_bytes, comp_source, at_end, fault
//  APB       in   payload_bytes at byte address 0
//
//  One beat is accepted per cycle while s_tready is high; its result beat appears in the next cycle.
//  The source table read, the chunk sizing and the state update all sit in
//  one combinational pass in front of the output register.
//  While a result beat waits on m_tready, s_tready drops until it is taken.
//  Reset is synchronous on aresetn; the source table is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fed_fragment_sequencer
    import ffs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [11:0] source_id, [17:12] source_count, [41:18] bytes_available
    input  logic [S_DATA_W-1:0] s_tdata,
    // [1:0] action
    input  logic [1:0]          s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [23:0] comp_bytes, [35:24] comp_source, [36] at_end, [37] fault
    output logic [M_DATA_W-1:0] m_tdata,
    // [1:0] comp_kind
    output logic [1:0]          m_tuser,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [BYTES_W-1:0] payload_bytes_reg;

    logic [SRC_W-1:0]   table_mem [MAX_SOURCES];
    logic [IDX_W-1:0]   load_ptr_reg,  load_ptr_next;
    logic [IDX_W-1:0]   src_total_reg, src_total_next;
    logic [IDX_W-1:0]   src_index_reg, src_index_next;
    kind_t              kind_reg,      kind_next;
    logic [BYTES_W-1:0] left_reg,      left_next;

    logic               out_valid_reg;
    kind_t              out_kind_reg,   out_kind_next;
    logic [BYTES_W-1:0] out_bytes_reg,  out_bytes_next;
    logic [SRC_W-1:0]   out_src_reg,    out_src_next;
    logic               out_end_reg,    out_end_next;
    logic               out_fault_reg,  out_fault_next;

    action_t            in_action;
    logic [SRC_W-1:0]   in_sid;
    logic [CNT_W-1:0]   in_count;
    logic [BYTES_W-1:0] in_avail;
    logic               accept;
    logic               finished;
    logic               table_wr;
    kind_t              cur_kind;
    logic [BYTES_W-1:0] chunk;

    assign in_action = action_t'(s_tuser);
    assign in_sid    = s_tdata[11:0];
    assign in_count  = s_tdata[17:12];
    assign in_avail  = s_tdata[41:18];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign finished = src_index_reg >= src_total_reg;
    assign table_wr = accept && (in_action == ACT_LOAD)
                      && (load_ptr_reg < IDX_W'(MAX_SOURCES));

    // kind_next never holds the unused code, but fold it onto header anyway.
    always_comb begin
        case (kind_reg)
            KIND_PAYLOAD: cur_kind = KIND_PAYLOAD;
            KIND_TRAILER: cur_kind = KIND_TRAILER;
            default:      cur_kind = KIND_HEADER;
        endcase
    end

    always_comb begin
        case (cur_kind)
            KIND_PAYLOAD: begin
                if (in_avail < BYTES_W'(CHUNK_UNIT)) begin
                    chunk = BYTES_W'(CHUNK_UNIT);
                end else if (left_reg > in_avail) begin
                    chunk = in_avail & ~BYTES_W'(CHUNK_UNIT - 1);
                end else begin
                    chunk = left_reg;
                end
            end
            KIND_TRAILER: chunk = BYTES_W'(TRAILER_BYTES);
            default:      chunk = BYTES_W'(HEADER_BYTES);
        endcase
    end

    always_comb begin
        load_ptr_next  = load_ptr_reg;
        src_total_next = src_total_reg;
        src_index_next = src_index_reg;
        kind_next      = kind_reg;
        left_next      = left_reg;
        out_kind_next  = KIND_HEADER;
        out_bytes_next = '0;
        out_src_next   = '0;
        out_fault_next = 1'b0;

        case (in_action)
            ACT_LOAD: begin
                if (load_ptr_reg < IDX_W'(MAX_SOURCES)) begin
                    load_ptr_next = load_ptr_reg + IDX_W'(1);
                end
            end
            ACT_START: begin
                if (IDX_W'(in_count) > IDX_W'(MAX_SOURCES)) begin
                    src_total_next = IDX_W'(MAX_SOURCES);
                end else begin
                    src_total_next = IDX_W'(in_count);
                end
                src_index_next = '0;
                load_ptr_next  = '0;
                kind_next      = KIND_HEADER;
                left_next      = '0;
            end
            default: begin
                if (finished) begin
                    out_fault_next = 1'b1;
                end else begin
                    out_kind_next  = cur_kind;
                    out_bytes_next = chunk;
                    out_src_next   = table_mem[src_index_reg[SLOT_W-1:0]];
                    if (in_action == ACT_CONSUME) begin
                        case (cur_kind)
                            KIND_PAYLOAD: begin
                                if (left_reg > chunk) begin
                                    left_next = left_reg - chunk;
                                end else begin
                                    left_next = '0;
                                    kind_next = KIND_TRAILER;
                                end
                            end
                            KIND_TRAILER: begin
                                kind_next      = KIND_HEADER;
                                src_index_next = src_index_reg + IDX_W'(1);
                            end
                            default: begin
                                if (payload_bytes_reg != '0) begin
                                    kind_next = KIND_PAYLOAD;
                                    left_next = payload_bytes_reg;
                                end else begin
                                    kind_next = KIND_TRAILER;
                                    left_next = '0;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase

        out_end_next = src_index_next >= src_total_next;
    end

    always_ff @(posedge aclk) begin
        if (table_wr) begin
            table_mem[load_ptr_reg[SLOT_W-1:0]] <= in_sid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_ptr_reg  <= '0;
            src_total_reg <= '0;
            src_index_reg <= '0;
            kind_reg      <= KIND_HEADER;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                load_ptr_reg  <= load_ptr_next;
                src_total_reg <= src_total_next;
                src_index_reg <= src_index_next;
                kind_reg      <= kind_next;
                left_reg      <= left_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_kind_reg  <= out_kind_next;
            out_bytes_reg <= out_bytes_next;
            out_src_reg   <= out_src_next;
            out_end_reg   <= out_end_next;
            out_fault_reg <= out_fault_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_fault_reg, out_end_reg, out_src_reg, out_bytes_reg};

    // APB register file: one register, word-decoded on paddr[2].
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_bytes_reg <= PAYLOAD_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_PAYLOAD_BYTES)) begin
            payload_bytes_reg <= pwdata[BYTES_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PAYLOAD_BYTES)
                    ? PDATA_W'(payload_bytes_reg) : '0;

endmodule

// ----- design/ffs_checker.sv -----
// ----------------------------------------------------------------------------
// ffs_checker
// Port-level checks on the fragment sequencer, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fed_fragment_sequencer_defines.svh"

module ffs_checker
    import ffs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [1:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [1:0]          m_tuser,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [PADDR_W-1:0]  paddr,
    input logic [PDATA_W-1:0]  pwdata,
    input logic [PDATA_W-1:0]  prdata,
    input logic                pready
);

    // A stalled result beat keeps its contents.
    `FFS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Every accepted beat yields a result beat on the next cycle.
    `FFS_ASSERT_NEXT(a_one_result, s_tvalid && s_tready, m_tvalid)

    // A fault beat carries no component and reports the end.
    `FFS_ASSERT_IMPL(a_fault_empty, m_tvalid && m_tdata[37], m_tdata[36] && (m_tdata[35:0] == 36'd0) && (m_tuser == KIND_HEADER))

    // A trailer always has its fixed size.
    `FFS_ASSERT_IMPL(a_trailer_size, m_tvalid && (m_tuser == KIND_TRAILER), m_tdata[23:0] == BYTES_W'(TRAILER_BYTES))

endmodule

bind fed_fragment_sequencer ffs_checker u_ffs_checker (.*);
